FILE: rtl/okm_pkg.sv
// shared types, codes and constants of the online k-means centroid update unit
package okm_pkg;

	localparam int LANES     = 8;
	localparam int ELEM_BITS = 16;
	localparam int DIST_BITS = 35;
	localparam int CFG_BITS  = 32;
	localparam int CFG_IDX_BITS = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_CLUSTERS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIMS_IN_USE     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ITERATION_LIMIT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ETA_EARLY       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ETA_LATE        = 3'd4;

	// register values after reset
	localparam logic [4:0]  RST_ACTIVE_CLUSTERS = 5'd2;
	localparam logic [3:0]  RST_DIMS_IN_USE     = 4'd8;
	localparam logic [31:0] RST_ITERATION_LIMIT = 32'd1000;
	localparam logic [15:0] RST_ETA_EARLY       = 16'd655;
	localparam logic [15:0] RST_ETA_LATE        = 16'd66;

	typedef enum logic [1:0] {
		KIND_LOAD    = 2'd0,
		KIND_TRAIN   = 2'd1,
		KIND_READ    = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RD_ITEM = 2'd0,
		RD_SCAN = 2'd1,
		RD_WIN  = 2'd2
	} rd_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_READ_WAIT,
		ST_RESTART,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_MUL,
		ST_APPLY
	} state_t;

	typedef struct packed {
		kind_t                        kind;
		logic [3:0]                   centroid_index;
		logic signed [ELEM_BITS-1:0]  elem0;
		logic signed [ELEM_BITS-1:0]  elem1;
		logic signed [ELEM_BITS-1:0]  elem2;
		logic signed [ELEM_BITS-1:0]  elem3;
		logic signed [ELEM_BITS-1:0]  elem4;
		logic signed [ELEM_BITS-1:0]  elem5;
		logic signed [ELEM_BITS-1:0]  elem6;
		logic signed [ELEM_BITS-1:0]  elem7;
	} item_t;

	typedef struct packed {
		logic [3:0]                   winner;
		logic [DIST_BITS-1:0]         distance;
		logic                         updated;
		logic signed [ELEM_BITS-1:0]  out0;
		logic signed [ELEM_BITS-1:0]  out1;
		logic signed [ELEM_BITS-1:0]  out2;
		logic signed [ELEM_BITS-1:0]  out3;
		logic signed [ELEM_BITS-1:0]  out4;
		logic signed [ELEM_BITS-1:0]  out5;
		logic signed [ELEM_BITS-1:0]  out6;
		logic signed [ELEM_BITS-1:0]  out7;
	} result_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic    capture;
		logic    rd_en;
		rd_src_t rd_src;
		logic    scan_step;
		logic    scan_tag;
		logic    mul;
		logic    load_wr;
		logic    res_load;
	} ctl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic scan_last;
	} dp_stat_t;

endpackage

FILE: rtl/okm_ram.sv
// generic single write port ram with registered read
module okm_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/okm_ctrl.sv
// controller state machine sequencing load, read, restart and train transactions
module okm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  okm_pkg::kind_t    kind,
	input  okm_pkg::dp_stat_t stat,
	output okm_pkg::ctl_cmd_t cmd,
	output logic              busy
);

	okm_pkg::state_t state_q, state_d;
	logic [1:0]      drain_q, drain_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= okm_pkg::ST_IDLE;
			drain_q <= 2'd0;
		end else begin
			state_q <= state_d;
			drain_q <= drain_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		drain_d = drain_q;
		cmd     = '0;
		cmd.rd_src = okm_pkg::RD_ITEM;
		busy    = 1'b1;
		case (state_q)
			okm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					case (kind)
						okm_pkg::KIND_LOAD:    state_d = okm_pkg::ST_LOAD;
						okm_pkg::KIND_TRAIN:   state_d = okm_pkg::ST_SCAN;
						okm_pkg::KIND_READ:    state_d = okm_pkg::ST_READ;
						okm_pkg::KIND_RESTART: state_d = okm_pkg::ST_RESTART;
						default:               state_d = okm_pkg::ST_RESTART;
					endcase
				end
			end
			okm_pkg::ST_LOAD: begin
				cmd.load_wr  = 1'b1;
				cmd.res_load = 1'b1;
				state_d      = okm_pkg::ST_IDLE;
			end
			okm_pkg::ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = okm_pkg::RD_ITEM;
				state_d    = okm_pkg::ST_READ_WAIT;
			end
			okm_pkg::ST_READ_WAIT: begin
				cmd.res_load = 1'b1;
				state_d      = okm_pkg::ST_IDLE;
			end
			okm_pkg::ST_RESTART: begin
				cmd.res_load = 1'b1;
				state_d      = okm_pkg::ST_IDLE;
			end
			// one centroid row issued per cycle
			okm_pkg::ST_SCAN: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_src    = okm_pkg::RD_SCAN;
				cmd.scan_tag  = 1'b1;
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = okm_pkg::ST_DRAIN;
					drain_d = 2'd0;
				end
			end
			// let the distance pipeline empty
			okm_pkg::ST_DRAIN: begin
				drain_d = drain_q + 2'd1;
				if (drain_q == 2'd2) begin
					state_d = okm_pkg::ST_FETCH;
				end
			end
			okm_pkg::ST_FETCH: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = okm_pkg::RD_WIN;
				state_d    = okm_pkg::ST_MUL;
			end
			okm_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = okm_pkg::ST_APPLY;
			end
			okm_pkg::ST_APPLY: begin
				cmd.res_load = 1'b1;
				state_d      = okm_pkg::ST_IDLE;
			end
			default: begin
				state_d = okm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/okm_dp.sv
// datapath: configuration, centroid store, distance pipeline, winner update
module okm_dp #(
	parameter int MAX_CLUSTERS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  okm_pkg::ctl_cmd_t                   cmd,
	output okm_pkg::dp_stat_t                   stat,
	input  okm_pkg::item_t                      item,
	input  logic                                cfg_we,
	input  logic [okm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [okm_pkg::CFG_BITS-1:0]        cfg_data,
	output okm_pkg::result_t                    result,
	output logic                                done
);

	localparam int AW = $clog2(MAX_CLUSTERS);
	localparam int L  = okm_pkg::LANES;
	localparam int EB = okm_pkg::ELEM_BITS;
	localparam int RW = L * EB;
	localparam int DB = okm_pkg::DIST_BITS;

	// configuration registers
	logic [4:0]  ac_q;
	logic [3:0]  nd_q;
	logic [31:0] lim_q;
	logic [15:0] etae_q, etal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_q   <= okm_pkg::RST_ACTIVE_CLUSTERS;
			nd_q   <= okm_pkg::RST_DIMS_IN_USE;
			lim_q  <= okm_pkg::RST_ITERATION_LIMIT;
			etae_q <= okm_pkg::RST_ETA_EARLY;
			etal_q <= okm_pkg::RST_ETA_LATE;
		end else if (cfg_we) begin
			case (cfg_index)
				okm_pkg::CFG_ACTIVE_CLUSTERS: ac_q   <= cfg_data[4:0];
				okm_pkg::CFG_DIMS_IN_USE:     nd_q   <= cfg_data[3:0];
				okm_pkg::CFG_ITERATION_LIMIT: lim_q  <= cfg_data;
				okm_pkg::CFG_ETA_EARLY:       etae_q <= cfg_data[15:0];
				okm_pkg::CFG_ETA_LATE:        etal_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// transaction capture
	okm_pkg::kind_t         kind_q;
	logic [3:0]             idx_q;
	logic signed [EB-1:0]   samp_q [L];
	logic signed [EB-1:0]   samp_d [L];

	always_comb begin
		samp_d[0] = item.elem0;
		samp_d[1] = item.elem1;
		samp_d[2] = item.elem2;
		samp_d[3] = item.elem3;
		samp_d[4] = item.elem4;
		samp_d[5] = item.elem5;
		samp_d[6] = item.elem6;
		samp_d[7] = item.elem7;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= item.kind;
			idx_q  <= item.centroid_index;
			samp_q <= samp_d;
		end
	end

	// clamped cluster and lane counts
	logic [AW-1:0] last_idx;
	logic [3:0]    nd_eff;
	logic [L-1:0]  lane_en;
	logic          idx_ok;

	always_comb begin
		if (ac_q == 5'd0) begin
			last_idx = '0;
		end else if ({27'd0, ac_q} > 32'(MAX_CLUSTERS)) begin
			last_idx = AW'(MAX_CLUSTERS - 1);
		end else begin
			last_idx = AW'(ac_q - 5'd1);
		end
		if (nd_q == 4'd0) begin
			nd_eff = 4'd1;
		end else if (nd_q > 4'(L)) begin
			nd_eff = 4'(L);
		end else begin
			nd_eff = nd_q;
		end
		for (int j = 0; j < L; j++) begin
			lane_en[j] = 4'(j) < nd_eff;
		end
		idx_ok = {28'd0, idx_q} < 32'(MAX_CLUSTERS);
	end

	// scan counter
	logic [AW-1:0] scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.capture) begin
			scan_q <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + AW'(1);
		end
	end

	assign stat.scan_last = (scan_q == last_idx);

	// centroid store
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr, win_q;
	logic [RW-1:0] ram_wdata, ram_rdata, load_row, upd_row;
	logic          upd;

	always_comb begin
		for (int j = 0; j < L; j++) begin
			load_row[j*EB +: EB] = samp_q[j];
		end
		case (cmd.rd_src)
			okm_pkg::RD_ITEM: ram_raddr = AW'(idx_q);
			okm_pkg::RD_SCAN: ram_raddr = scan_q;
			okm_pkg::RD_WIN:  ram_raddr = win_q;
			default:          ram_raddr = win_q;
		endcase
		if (cmd.load_wr) begin
			ram_we    = idx_ok;
			ram_waddr = AW'(idx_q);
			ram_wdata = load_row;
		end else begin
			ram_we    = cmd.res_load && (kind_q == okm_pkg::KIND_TRAIN) && upd;
			ram_waddr = win_q;
			ram_wdata = upd_row;
		end
	end

	okm_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_CLUSTERS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic signed [EB-1:0] row_rd [L];

	always_comb begin
		for (int j = 0; j < L; j++) begin
			row_rd[j] = ram_rdata[j*EB +: EB];
		end
	end

	// distance pipeline: tag, squares, sum, best compare
	logic          v_s0, v_s1, v_s2;
	logic [AW-1:0] c_s0, c_s1, c_s2;
	logic [31:0]   sq_s1 [L];
	logic [DB-1:0] dsum_s2;
	logic [DB-1:0] best_q;
	logic [31:0]   sq_d [L];
	logic [DB-1:0] sum_d;

	always_comb begin
		logic signed [EB:0] diff;
		logic [EB-1:0]      mag;
		for (int j = 0; j < L; j++) begin
			diff    = (EB+1)'(samp_q[j]) - (EB+1)'(row_rd[j]);
			mag     = diff[EB] ? EB'(-diff) : EB'(diff);
			sq_d[j] = lane_en[j] ? (32'(mag) * 32'(mag)) : 32'd0;
		end
		sum_d = '0;
		for (int j = 0; j < L; j++) begin
			sum_d = sum_d + DB'(sq_s1[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s0 <= cmd.scan_tag;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		c_s0    <= scan_q;
		c_s1    <= c_s0;
		c_s2    <= c_s1;
		sq_s1   <= sq_d;
		dsum_s2 <= sum_d;
		if (v_s2 && ((c_s2 == '0) || (dsum_s2 < best_q))) begin
			best_q <= dsum_s2;
			win_q  <= c_s2;
		end
	end

	// trained count
	logic [31:0] cnt_q;

	assign upd = cnt_q < lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.res_load && (kind_q == okm_pkg::KIND_RESTART)) begin
			cnt_q <= '0;
		end else if (cmd.res_load && (kind_q == okm_pkg::KIND_TRAIN) && upd) begin
			cnt_q <= cnt_q + 32'd1;
		end
	end

	// winner update: scaled difference, then rounding add with saturation
	logic signed [EB+17:0] prod_q [L];
	logic signed [EB-1:0]  row_q  [L];
	logic signed [EB-1:0]  new_row [L];
	logic [15:0]           eta;

	assign eta = (cnt_q <= (lim_q >> 1)) ? etae_q : etal_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int j = 0; j < L; j++) begin
				prod_q[j] <= (EB+18)'(((EB+1)'(samp_q[j]) - (EB+1)'(row_rd[j]))
					* $signed({1'b0, eta}));
			end
			row_q <= row_rd;
		end
	end

	always_comb begin
		logic signed [EB+18:0] p;
		logic signed [EB+2:0]  delta;
		logic signed [EB+3:0]  r;
		for (int j = 0; j < L; j++) begin
			p     = (EB+19)'(prod_q[j]) + (EB+19)'(32768);
			delta = p[EB+18:16];
			r     = (EB+4)'(row_q[j]) + (EB+4)'(delta);
			if (r > (EB+4)'((2 ** (EB-1)) - 1)) begin
				new_row[j] = {1'b0, {(EB-1){1'b1}}};
			end else if (r < -(EB+4)'(2 ** (EB-1))) begin
				new_row[j] = {1'b1, {(EB-1){1'b0}}};
			end else begin
				new_row[j] = r[EB-1:0];
			end
			if (!lane_en[j] || !upd) begin
				new_row[j] = row_q[j];
			end
			upd_row[j*EB +: EB] = new_row[j];
		end
	end

	// result assembly
	okm_pkg::result_t     res_d, res_q;
	logic signed [EB-1:0] out_row [L];
	logic                 done_q;

	always_comb begin
		res_d        = '0;
		res_d.winner = idx_q;
		for (int j = 0; j < L; j++) begin
			out_row[j] = '0;
		end
		case (kind_q)
			okm_pkg::KIND_LOAD: begin
				if (idx_ok) begin
					out_row = samp_q;
				end
			end
			okm_pkg::KIND_READ: begin
				if (idx_ok) begin
					out_row = row_rd;
				end
			end
			okm_pkg::KIND_TRAIN: begin
				res_d.winner   = 4'(win_q);
				res_d.distance = best_q;
				res_d.updated  = upd;
				out_row        = new_row;
			end
			default: ;
		endcase
		res_d.out0 = out_row[0];
		res_d.out1 = out_row[1];
		res_d.out2 = out_row[2];
		res_d.out3 = out_row[3];
		res_d.out4 = out_row[4];
		res_d.out5 = out_row[5];
		res_d.out6 = out_row[6];
		res_d.out7 = out_row[7];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
		end
	end

	assign result = res_q;
	assign done   = done_q;

endmodule

FILE: rtl/online_kmeans_centroid_update_unit.sv
// top level of the online k-means centroid update unit
//
// channel   direction  handshake                      payload
// command   in         start && !busy                 item (okm_pkg::item_t)
// result    out        done, one cycle, no back-off   result (okm_pkg::result_t)
// config    in         cfg_we                         cfg_index, cfg_data
//
// load writes the store and registers the result; restart registers the result;
// read does a registered ram read, then registers the result; train scans one ram row
// per cycle, drains the distance pipeline, then does a winner fetch, multiply and update
// busy is high from the accept until the result is registered; one transaction at a time
// reset clears control, configuration and the trained count; the store holds no reset
module online_kmeans_centroid_update_unit #(
	parameter int MAX_CLUSTERS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  okm_pkg::item_t                   item,
	output logic                             done,
	output okm_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [okm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [okm_pkg::CFG_BITS-1:0]     cfg_data
);

	okm_pkg::ctl_cmd_t cmd;
	okm_pkg::dp_stat_t stat;

	// controller
	okm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	okm_dp #(
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in progress");
`endif

endmodule
